FILE: rtl/core/isd_pkg.sv
// ----------------------------------------------------------------------------
// isd_pkg: step detector and speed estimator shared definitions
// Widths, register indexes, reset values and payload types used by the core,
// the register file and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package isd_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned TimeBits   = 32;

  localparam int unsigned ThreshBits = 16;
  localparam int unsigned HeightBits = 8;
  localparam int unsigned WinCntBits = 8;
  localparam int unsigned TotalBits  = 24;
  localparam int unsigned SpeedBits  = 16;

  // stride speed factor: height in cm * 4150 gives mm/s per step per ms
  localparam int unsigned StrideSpeedFactor = 4150;
  localparam int unsigned FactorBits        = 13;

  // speed numerator: window steps * height * factor
  localparam int unsigned ProdBits = WinCntBits + HeightBits + FactorBits;

  // shared multiplier operand width (signed)
  localparam int unsigned MulBits =
      (SampleBits + 1 > WinCntBits + HeightBits + 1) ? SampleBits + 1
                                                     : WinCntBits + HeightBits + 1;

  localparam int unsigned SqBits   = 2 * SampleBits;
  localparam int unsigned RootBits = SampleBits;

  // shared compare/subtract unit width: covers root remainder and divider remainder
  localparam int unsigned AluBits =
      (SampleBits + 3 > ThreshBits + 1) ? SampleBits + 3 : ThreshBits + 1;

  localparam int unsigned CmpBits = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;

  localparam int unsigned CntBits = $clog2((ProdBits > RootBits) ? ProdBits : RootBits);

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_STEP_HIGH = 3'd0,
    REG_STEP_LOW  = 3'd1,
    REG_GYRO      = 3'd2,
    REG_MIN_GAP   = 3'd3,
    REG_WINDOW    = 3'd4,
    REG_HEIGHT    = 3'd5
  } cfg_reg_e;

  localparam logic [ThreshBits-1:0] StepHighReset = 16'd70;
  localparam logic [ThreshBits-1:0] StepLowReset  = 16'd20;
  localparam logic [ThreshBits-1:0] GyroReset     = 16'd80;
  localparam logic [ThreshBits-1:0] MinGapReset   = 16'd300;
  localparam logic [ThreshBits-1:0] WindowReset   = 16'd1000;
  localparam logic [HeightBits-1:0] HeightReset   = 8'd170;

  typedef struct packed {
    logic [ThreshBits-1:0] peak_thresh;
    logic [ThreshBits-1:0] rest_thresh;
    logic [ThreshBits-1:0] gyro_thresh;
    logic [ThreshBits-1:0] min_step_gap_ms;
    logic [ThreshBits-1:0] window_len_ms;
    logic [HeightBits-1:0] user_height_cm;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] accel_x;
    logic signed [SampleBits-1:0] gyro_x;
    logic signed [SampleBits-1:0] gyro_y;
    logic signed [SampleBits-1:0] gyro_z;
    logic        [TimeBits-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic                  step_detected;
    logic [TotalBits-1:0]  step_total;
    logic                  window_closed;
    logic [WinCntBits-1:0] window_step_count;
    logic [SpeedBits-1:0]  speed_mm_per_s;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/imu_step_detector_speed_unit.sv
// ----------------------------------------------------------------------------
// imu_step_detector_speed_unit: threshold pedometer with windowed speed
// Top level: configuration registers and the iterative detector core.
// ----------------------------------------------------------------------------
// One request is one IMU sample; each gives exactly one result. The block takes
// a request only when idle and handles it alone: the gyro axes are squared on
// one shared multiplier, the magnitude root is found one bit per cycle over
// its 16 bits, and then the step decision is made. A sample that closes the
// speed window adds two multiplies on the shared multiplier and a restoring
// divide of one quotient bit per cycle over the 29-bit numerator, the divide
// on the compare/subtract unit shared with the root. A finished result sits
// in an output register, so the next request is taken while it waits.
// Configuration writes are taken every cycle and must only be issued while no
// request is in flight.
`default_nettype none

module imu_step_detector_speed_unit import isd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_data_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  cfg_t cfg;

  isd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  isd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/isd_cfg.sv
// ----------------------------------------------------------------------------
// isd_cfg: configuration register file
// Holds the six thresholds and settings; writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module isd_cfg import isd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_thresh     <= StepHighReset;
      cfg_q.rest_thresh     <= StepLowReset;
      cfg_q.gyro_thresh     <= GyroReset;
      cfg_q.min_step_gap_ms <= MinGapReset;
      cfg_q.window_len_ms   <= WindowReset;
      cfg_q.user_height_cm  <= HeightReset;
    end else if (cfg_valid_i) begin
      // drop writes to unknown indexes
      case (cfg_index_i)
        REG_STEP_HIGH: cfg_q.peak_thresh     <= cfg_data_i[ThreshBits-1:0];
        REG_STEP_LOW:  cfg_q.rest_thresh     <= cfg_data_i[ThreshBits-1:0];
        REG_GYRO:      cfg_q.gyro_thresh     <= cfg_data_i[ThreshBits-1:0];
        REG_MIN_GAP:   cfg_q.min_step_gap_ms <= cfg_data_i[ThreshBits-1:0];
        REG_WINDOW:    cfg_q.window_len_ms   <= cfg_data_i[ThreshBits-1:0];
        REG_HEIGHT:    cfg_q.user_height_cm  <= cfg_data_i[HeightBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/isd_alu.sv
// ----------------------------------------------------------------------------
// isd_alu: shared compare and subtract unit
// Gives a - b and whether a >= b; used by the square root and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module isd_alu import isd_pkg::*; (
  input  wire logic [AluBits-1:0] a_i,
  input  wire logic [AluBits-1:0] b_i,
  output logic      [AluBits-1:0] diff_o,
  output logic                    ge_o
);

  logic [AluBits:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = sub[AluBits-1:0];
  assign ge_o   = ~sub[AluBits];

endmodule

`default_nettype wire

FILE: rtl/core/isd_core.sv
// ----------------------------------------------------------------------------
// isd_core: step detector sequencer and datapath
// Squares the gyro axes on one multiplier, takes the root one bit per cycle,
// decides the step, and on window close forms and divides the speed numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module isd_core import isd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  localparam int unsigned NumAxes = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_DECIDE,
    ST_SPD_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [CntBits-1:0] cnt_q;

  // sample
  logic signed [SampleBits-1:0] ax_q, gx_q, gy_q, gz_q;
  logic [TimeBits-1:0] now_q;

  // arithmetic
  logic signed [2*MulBits-1:0] prod_q;
  logic [SqBits-1:0]   sum_q;
  logic [SqBits-1:0]   rad_q;
  logic [AluBits-1:0]  rem_q;
  logic [RootBits-1:0] root_q;
  logic [ProdBits-1:0] dvd_q;

  // detector state
  logic                         latch_q;
  logic signed [SampleBits-1:0] prev_accel_q;
  logic [RootBits-1:0]          prev_gmag_q;
  logic [TimeBits-1:0]          last_step_q;
  logic [TimeBits-1:0]          win_start_q;
  logic [WinCntBits-1:0]        win_steps_q;
  logic [TotalBits-1:0]         total_q;
  logic [SpeedBits-1:0]         speed_q;

  // per-item flags
  logic                  stepped_q;
  logic                  closed_q;
  logic [WinCntBits-1:0] win_rep_q;

  logic      out_valid_q;
  out_item_t out_q;

  // multiplier
  logic signed [MulBits-1:0]   mul_a, mul_b;
  logic signed [2*MulBits-1:0] mul_p;
  logic [SqBits-1:0]           sum_next;

  // shared unit
  logic [AluBits-1:0] alu_a, alu_b, alu_diff;
  logic               alu_ge;
  logic [AluBits-1:0] root_shift, div_shift;
  logic [ThreshBits-1:0] divisor;

  // decision
  logic signed [SampleBits:0] acc_diff;
  logic [SampleBits:0]        acc_abs;
  logic [CmpBits-1:0]         d_acc, d_gyro;
  logic [TimeBits-1:0]        since_step, since_win;
  logic                       step_hit, latch_clear, win_hit;
  logic [WinCntBits-1:0]      win_steps_new;
  logic [SpeedBits-1:0]       speed_sat;

  always_comb begin
    mul_a = MulBits'(gz_q);
    mul_b = MulBits'(gz_q);
    if (state_q == ST_SPD_MUL) begin
      if (cnt_q == '0) begin
        mul_a = MulBits'(win_rep_q);
        mul_b = MulBits'(cfg_i.user_height_cm);
      end else begin
        mul_a = MulBits'(prod_q[WinCntBits+HeightBits-1:0]);
        mul_b = MulBits'(FactorBits'(StrideSpeedFactor));
      end
    end else if (cnt_q == CntBits'(0)) begin
      mul_a = MulBits'(gx_q);
      mul_b = MulBits'(gx_q);
    end else if (cnt_q == CntBits'(1)) begin
      mul_a = MulBits'(gy_q);
      mul_b = MulBits'(gy_q);
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign sum_next = sum_q + prod_q[SqBits-1:0];

  assign root_shift = {rem_q[AluBits-3:0], rad_q[SqBits-1 -: 2]};
  assign div_shift  = {rem_q[AluBits-2:0], dvd_q[ProdBits-1]};
  // zero window length divides by one
  assign divisor    = (cfg_i.window_len_ms == '0) ? ThreshBits'(1) : cfg_i.window_len_ms;

  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a = div_shift;
      alu_b = AluBits'(divisor);
    end else begin
      alu_a = root_shift;
      alu_b = AluBits'({root_q, 2'b01});
    end
  end

  isd_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  always_comb begin
    acc_diff   = {ax_q[SampleBits-1], ax_q} - {prev_accel_q[SampleBits-1], prev_accel_q};
    acc_abs    = acc_diff[SampleBits] ? SampleBits'(0) - acc_diff : acc_diff;
    d_acc      = CmpBits'(acc_abs[SampleBits-1:0]);
    d_gyro     = (root_q >= prev_gmag_q) ? CmpBits'(root_q - prev_gmag_q)
                                         : CmpBits'(prev_gmag_q - root_q);
    since_step = now_q - last_step_q;
    since_win  = now_q - win_start_q;
    step_hit   = !latch_q
                 && (d_acc > CmpBits'(cfg_i.peak_thresh))
                 && (d_gyro > CmpBits'(cfg_i.gyro_thresh))
                 && (since_step > TimeBits'(cfg_i.min_step_gap_ms));
    latch_clear = latch_q
                 && (d_acc < CmpBits'(cfg_i.rest_thresh))
                 && (d_gyro < CmpBits'(cfg_i.gyro_thresh));
    win_hit    = since_win >= TimeBits'(cfg_i.window_len_ms);
    win_steps_new = (step_hit && win_steps_q != '1) ? win_steps_q + 1'b1 : win_steps_q;
    speed_sat  = (|dvd_q[ProdBits-1:SpeedBits]) ? '1 : dvd_q[SpeedBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      ax_q         <= '0;
      gx_q         <= '0;
      gy_q         <= '0;
      gz_q         <= '0;
      now_q        <= '0;
      prod_q       <= '0;
      sum_q        <= '0;
      rad_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      dvd_q        <= '0;
      latch_q      <= 1'b0;
      prev_accel_q <= '0;
      prev_gmag_q  <= '0;
      last_step_q  <= '0;
      win_start_q  <= '0;
      win_steps_q  <= '0;
      total_q      <= '0;
      speed_q      <= '0;
      stepped_q    <= 1'b0;
      closed_q     <= 1'b0;
      win_rep_q    <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // the output step reloads the register itself
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ax_q    <= in_data_i.accel_x;
            gx_q    <= in_data_i.gyro_x;
            gy_q    <= in_data_i.gyro_y;
            gz_q    <= in_data_i.gyro_z;
            now_q   <= in_data_i.time_ms;
            cnt_q   <= '0;
            state_q <= ST_SQR;
          end
        end
        ST_SQR: begin
          // one axis squared per cycle, accumulate the previous square
          prod_q <= mul_p;
          sum_q  <= (cnt_q == '0) ? '0 : sum_next;
          if (cnt_q == CntBits'(NumAxes)) begin
            rad_q   <= sum_next;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_ROOT: begin
          // one root bit per cycle
          rad_q <= rad_q << 2;
          if (alu_ge) begin
            rem_q  <= alu_diff;
            root_q <= {root_q[RootBits-2:0], 1'b1};
          end else begin
            rem_q  <= root_shift;
            root_q <= {root_q[RootBits-2:0], 1'b0};
          end
          if (cnt_q == CntBits'(RootBits - 1)) begin
            state_q <= ST_DECIDE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DECIDE: begin
          stepped_q <= step_hit;
          closed_q  <= win_hit;
          win_rep_q <= win_steps_new;
          if (step_hit) begin
            latch_q     <= 1'b1;
            last_step_q <= now_q;
            if (total_q != '1) begin
              total_q <= total_q + 1'b1;
            end
          end else if (latch_clear) begin
            latch_q <= 1'b0;
          end
          prev_accel_q <= ax_q;
          prev_gmag_q  <= root_q;
          cnt_q        <= '0;
          if (win_hit) begin
            win_steps_q <= '0;
            win_start_q <= now_q;
            state_q     <= ST_SPD_MUL;
          end else begin
            win_steps_q <= win_steps_new;
            state_q     <= ST_OUT;
          end
        end
        ST_SPD_MUL: begin
          // steps * height, then * factor, then load the divider
          if (cnt_q == CntBits'(2)) begin
            dvd_q   <= prod_q[ProdBits-1:0];
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            prod_q <= mul_p;
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (alu_ge) begin
            rem_q <= alu_diff;
            dvd_q <= {dvd_q[ProdBits-2:0], 1'b1};
          end else begin
            rem_q <= div_shift;
            dvd_q <= {dvd_q[ProdBits-2:0], 1'b0};
          end
          if (cnt_q == CntBits'(ProdBits - 1)) begin
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q             <= 1'b1;
            out_q.step_detected     <= stepped_q;
            out_q.step_total        <= total_q;
            out_q.window_closed     <= closed_q;
            out_q.window_step_count <= win_rep_q;
            out_q.speed_mm_per_s    <= closed_q ? speed_sat : speed_q;
            if (closed_q) begin
              speed_q <= speed_sat;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_needs_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_SPD_MUL) |-> closed_q)
    else $error("speed path entered without a closed window");

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (cnt_q < CntBits'(RootBits)))
    else $error("root iteration count out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQR && !in_ready_o))
    else $error("accepted request did not start the squaring pass");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

FILE: sim/imu_step_detector_speed_unit_test.sv
// ----------------------------------------------------------------------------
// imu_step_detector_speed_unit_test: pedometer and speed window check
// Feeds IMU samples through the valid/ready request channel, tracks step
// latch, step gap, window count and speed in a local model, and compares each
// result field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------

module imu_step_detector_speed_unit_test;
  import isd_pkg::*;

  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned DrainCycles    = 80;
  localparam int unsigned LongHoldCycles = 300;

  logic                   clk_i;
  logic                   rst_ni    = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data  = '0;

  imu_step_detector_speed_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // local copy of the register file and the pedometer state
  cfg_t                  regs = '{StepHighReset, StepLowReset, GyroReset,
                                  MinGapReset, WindowReset, HeightReset};
  logic                  latch_set;
  int                    last_accel;
  int                    last_gyro_mag;
  logic [TimeBits-1:0]   last_step_ms;
  logic [TimeBits-1:0]   window_open_ms;
  logic [WinCntBits-1:0] steps_in_window;
  logic [TotalBits-1:0]  steps_overall;
  logic [SpeedBits-1:0]  speed_est;

  in_item_t  imu_sample_q[$];
  out_item_t gait_report_q[$];

  logic idling_on = 1'b1;
  int   err_cnt, samples_sent, results_checked, settings_used;
  int   steps_counted, windows_closed, peak_window;
  int   sender_gap, rx_gap, rx_long, quiet_cycles;

  // sample generator state
  logic [TimeBits-1:0] walk_ms;
  int                  walk_acc;
  int                  walk_gyro[3];
  logic                walk_loud, walk_rest;

  function automatic int unsigned root_floor(longint unsigned n);
    longint unsigned root, cand;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= n) root = cand;
    end
    return int'(root);
  endfunction

  function automatic int unsigned abs_gap(int a, int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // advance the pedometer by one sample and queue the report it must give
  function automatic void count_step_and_speed(in_item_t s);
    longint              gx, gy, gz;
    int                  mag;
    int unsigned         acc_jump, gyro_jump;
    logic [TimeBits-1:0] since_step, since_window;
    longint unsigned     numer, divisor, quot;
    out_item_t           r;
    gx = s.gyro_x;
    gy = s.gyro_y;
    gz = s.gyro_z;
    mag = root_floor(gx * gx + gy * gy + gz * gz);
    acc_jump = abs_gap(int'(s.accel_x), last_accel);
    gyro_jump = abs_gap(mag, last_gyro_mag);
    since_step = s.time_ms - last_step_ms;
    since_window = s.time_ms - window_open_ms;
    r = '0;
    if (!latch_set && acc_jump > regs.peak_thresh &&
        gyro_jump > regs.gyro_thresh && since_step > regs.min_step_gap_ms) begin
      latch_set = 1'b1;
      r.step_detected = 1'b1;
      if (steps_overall != '1) steps_overall++;
      if (steps_in_window != '1) steps_in_window++;
      last_step_ms = s.time_ms;
      steps_counted++;
    end else if (latch_set && acc_jump < regs.rest_thresh &&
                 gyro_jump < regs.gyro_thresh) begin
      latch_set = 1'b0;
    end
    r.window_step_count = steps_in_window;
    if (peak_window < steps_in_window) peak_window = steps_in_window;
    if (since_window >= regs.window_len_ms) begin
      divisor = (regs.window_len_ms == 0) ? 1 : regs.window_len_ms;
      numer = steps_in_window;
      numer = numer * regs.user_height_cm * StrideSpeedFactor;
      quot = numer / divisor;
      speed_est = (quot > 65535) ? '1 : quot[SpeedBits-1:0];
      r.window_closed = 1'b1;
      steps_in_window = '0;
      window_open_ms = s.time_ms;
      windows_closed++;
    end
    last_accel = s.accel_x;
    last_gyro_mag = mag;
    r.step_total = steps_overall;
    r.speed_mm_per_s = speed_est;
    gait_report_q = {gait_report_q, r};
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_report(out_item_t got);
    out_item_t want;
    if (gait_report_q.size() == 0) begin
      err_cnt++;
      $display("%0t: result with no sample pending, expected none, got %p", $time, got);
      return;
    end
    want = gait_report_q.pop_front();
    results_checked++;
    check_field("step_detected", want.step_detected, got.step_detected);
    check_field("step_total", want.step_total, got.step_total);
    check_field("window_closed", want.window_closed, got.window_closed);
    check_field("window_step_count", want.window_step_count, got.window_step_count);
    check_field("speed_mm_per_s", want.speed_mm_per_s, got.speed_mm_per_s);
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sender_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        count_step_and_speed(in_data);
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (sender_gap > 0) begin
          sender_gap <= sender_gap - 1;
          in_valid <= 1'b0;
        end else if (imu_sample_q.size() > 0 &&
                     !(idling_on && $urandom_range(0, 5) == 0)) begin
          in_data <= imu_sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (imu_sample_q.size() > 0) sender_gap <= $urandom_range(0, 5);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      rx_long <= 0;
    end else begin : receive
      logic hold_now;
      hold_now = 1'b0;
      if (out_valid && out_ready) begin
        check_report(out_data);
        hold_now = (results_checked == 60 || results_checked == 700);
      end
      // hold off long enough that the block backs up into the sender
      if (hold_now) begin
        rx_long <= LongHoldCycles;
        out_ready <= 1'b0;
      end else if (rx_long > 0) begin
        rx_long <= rx_long - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, IdleLimit, gait_report_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic void push_sample(int ax, int gx, int gy, int gz, logic [31:0] t);
    in_item_t s;
    s.accel_x = SampleBits'(ax);
    s.gyro_x = SampleBits'(gx);
    s.gyro_y = SampleBits'(gy);
    s.gyro_z = SampleBits'(gz);
    s.time_ms = t;
    imu_sample_q = {imu_sample_q, s};
  endfunction

  task automatic put_register(cfg_reg_e idx, logic [CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic write_registers(cfg_t c);
    put_register(REG_STEP_HIGH, c.peak_thresh);
    put_register(REG_STEP_LOW, c.rest_thresh);
    put_register(REG_GYRO, c.gyro_thresh);
    put_register(REG_MIN_GAP, c.min_step_gap_ms);
    put_register(REG_WINDOW, c.window_len_ms);
    // upper byte is junk: height is only 8 bits wide
    put_register(REG_HEIGHT, {8'($urandom), c.user_height_cm});
    cfg_valid <= 1'b0;
    regs = c;
    settings_used++;
  endtask

  task automatic await_idle();
    do @(negedge clk_i);
    while (imu_sample_q.size() != 0 || in_valid || gait_report_q.size() != 0);
    @(posedge clk_i);
  endtask

  // walking pattern: peaks alternate with near-repeats, plus raw noise
  task automatic queue_walk(int count, int dt_lo, int dt_hi, int noise_pct);
    in_item_t s;
    int       mag;
    @(negedge clk_i);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        s = in_item_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 1)) s.time_ms = walk_ms + $urandom_range(dt_lo, dt_hi);
        walk_ms = s.time_ms;
      end else begin
        walk_ms += $urandom_range(dt_lo, dt_hi);
        if (!walk_rest) begin
          walk_loud = !walk_loud;
          mag = $urandom_range(1000, 32767);
          walk_acc = (walk_acc >= 0) ? -mag : mag;
          foreach (walk_gyro[k])
            walk_gyro[k] = walk_loud ?
                ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(8000, 18000)) :
                int'($urandom_range(0, 400)) - 200;
        end else begin
          walk_acc = sat16(walk_acc + int'($urandom_range(0, 20)) - 10);
          foreach (walk_gyro[k])
            walk_gyro[k] = sat16(walk_gyro[k] + int'($urandom_range(0, 16)) - 8);
        end
        walk_rest = !walk_rest;
        s.accel_x = SampleBits'(walk_acc);
        s.gyro_x = SampleBits'(walk_gyro[0]);
        s.gyro_y = SampleBits'(walk_gyro[1]);
        s.gyro_z = SampleBits'(walk_gyro[2]);
        s.time_ms = walk_ms;
      end
      imu_sample_q = {imu_sample_q, s};
    end
  endtask

  initial begin
    cfg_t c;
    latch_set = 1'b0;
    last_accel = 0;
    last_gyro_mag = 0;
    last_step_ms = '0;
    window_open_ms = '0;
    steps_in_window = '0;
    steps_overall = '0;
    speed_est = '0;
    walk_ms = 32'h0000_0600;
    walk_acc = 0;
    walk_gyro = '{0, 0, 0};
    walk_loud = 1'b0;
    walk_rest = 1'b0;
    settings_used = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed samples against the reset register values
    @(negedge clk_i);
    push_sample(0, 0, 0, 0, 0);
    push_sample(32767, -32768, -32768, -32768, 400);   // step at full scale
    push_sample(-32768, -32768, -32768, -32768, 500);  // latched, no clear
    push_sample(-32768, -32768, -32768, -32768, 600);  // quiet: latch clears
    push_sample(32767, 0, 0, 0, 700);                  // gap exactly the minimum
    push_sample(0, 32767, 0, 0, 1001);                 // step on the closing sample
    push_sample(0, 32767, 0, 0, 1002);
    push_sample(70, 0, 0, 0, 1400);                    // accel change at threshold
    push_sample(141, 0, 0, 81, 1800);                  // just above both thresholds
    push_sample(161, 0, 0, 81, 1900);                  // low threshold not crossed
    push_sample(180, 0, 0, 100, 2000);                 // just below: clear
    push_sample(180, 0, 0, 100, 2001);                 // window length exactly
    push_sample(-20000, 20000, -20000, 20000, 32'hFFFF_FF00);
    push_sample(-20000, 20000, -20000, 20000, 32'h0000_0010);
    push_sample(20000, 0, 0, 0, 32'h0000_0050);        // step gap across the wrap
    push_sample(20000, 0, 0, 0, 32'h0000_0400);        // window closes across the wrap
    push_sample(-1, -1, 32767, -32768, 32'h0000_0500);
    await_idle();

    c.peak_thresh = ThreshBits'($urandom_range(40, 400));
    c.rest_thresh = ThreshBits'($urandom_range(5, 60));
    c.gyro_thresh = ThreshBits'($urandom_range(40, 400));
    c.min_step_gap_ms = ThreshBits'($urandom_range(0, 300));
    c.window_len_ms = ThreshBits'($urandom_range(300, 2000));
    c.user_height_cm = HeightBits'($urandom_range(50, 250));
    write_registers(c);
    queue_walk(150, 0, 120, 15);
    await_idle();

    // zero window, zero gap: every sample closes, speed saturates on a step
    write_registers('{16'd0, 16'hFFFF, 16'd200, 16'd0, 16'd0, 8'd255});
    queue_walk(60, 0, 50, 20);
    await_idle();

    // nothing can count a step; zero height
    write_registers('{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0});
    queue_walk(60, 0, 600, 20);
    await_idle();

    // step every other sample inside one long window: window count saturates
    write_registers('{16'd0, 16'hFFFF, 16'd150, 16'd0, 16'hFFFF, 8'd250});
    queue_walk(520, 1, 2, 0);
    push_sample(0, 0, 0, 0, walk_ms + 70000);
    walk_ms += 70000;
    await_idle();

    idling_on <= 1'b0;
    write_registers('{StepHighReset, StepLowReset, GyroReset, MinGapReset,
                      WindowReset, HeightReset});
    queue_walk(100, 0, 150, 10);
    await_idle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d IMU samples under %0d register settings, %0d results checked.",
             samples_sent, settings_used, results_checked);
    $display("Steps counted %0d, speed windows closed %0d, largest window count %0d.",
             steps_counted, windows_closed, peak_window);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
